### design/mm2h_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm2h_pkg
// Shared constants and controller/datapath interface types for the
// MurmurHash2 32-bit hash block.
// ----------------------------------------------------------------------------
package mm2h_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          AVAL_SHIFT1 = 13;
    localparam int          AVAL_SHIFT2 = 15;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 3;
    localparam int LEN_W   = 32;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_HMUL,
        S_KMUL1,
        S_KMUL2,
        S_KFOLD,
        S_TAIL_MUL,
        S_TAIL_LOAD,
        S_AVAL_MUL,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        MUL_HASH,
        MUL_WORD,
        MUL_KSHIFT,
        MUL_TAIL,
        MUL_AVAL
    } mul_op_t;

    typedef enum logic [1:0] {
        H_HOLD,
        H_START,
        H_PROD,
        H_XOR_PROD
    } h_op_t;

    typedef enum logic [1:0] {
        CNT_EMPTY,
        CNT_PART,
        CNT_FULL
    } cnt_class_t;

    typedef struct packed {
        logic    load;
        logic    mul_en;
        mul_op_t mul_op;
        h_op_t   h_op;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic       last;
        cnt_class_t cls;
        logic       out_free;
    } dp_status_t;

endpackage

### design/murmur2_hash32.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2_hash32
// Streaming 32-bit MurmurHash2 of a byte message, one word per transfer.
// A transfer is stepped through its states (empty, 1-3 bytes or full word)
// before the next is accepted; the single shared multiplier runs one product a cycle.
// A last transfer adds the avalanche (S_AVAL_MUL, S_DONE) before m_tvalid rises,
// plus any wait while an earlier result is still held.
// Reset: synchronous active-low aresetn clears seed to 0, output valid and
// message state; the next transfer starts a new message.
// ----------------------------------------------------------------------------
module murmur2_hash32 (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // data_word[31:0], bytes_valid[34:32], message_length[66:35], zero fill
    input  logic [mm2h_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hash_value[31:0]
    output logic [mm2h_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [31:0]                   cfg_data
);

    mm2h_pkg::dp_cmd_t    cmd;
    mm2h_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    mm2h_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mm2h_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    a_result_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("result valid without a load");

    a_load_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !cmd.mul_en && !cmd.out_load)
        else $error("load overlaps datapath activity");

endmodule

### design/mm2h_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm2h_ctrl
// Sequencer for the hash datapath: steps each non-empty word through the shared
// multiplier and runs the final avalanche on the last transfer.
// ----------------------------------------------------------------------------
module mm2h_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mm2h_pkg::dp_status_t status,
    output mm2h_pkg::dp_cmd_t    cmd
);

    mm2h_pkg::state_t state_reg;
    mm2h_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mm2h_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mm2h_pkg::S_IDLE: begin
                if (in_valid) begin
                    state_next = mm2h_pkg::S_DISPATCH;
                end
            end
            mm2h_pkg::S_DISPATCH: begin
                unique case (status.cls)
                    mm2h_pkg::CNT_FULL: state_next = mm2h_pkg::S_HMUL;
                    mm2h_pkg::CNT_PART: state_next = mm2h_pkg::S_TAIL_MUL;
                    default: begin
                        state_next = status.last ? mm2h_pkg::S_AVAL_MUL : mm2h_pkg::S_IDLE;
                    end
                endcase
            end
            mm2h_pkg::S_HMUL:      state_next = mm2h_pkg::S_KMUL1;
            mm2h_pkg::S_KMUL1:     state_next = mm2h_pkg::S_KMUL2;
            mm2h_pkg::S_KMUL2:     state_next = mm2h_pkg::S_KFOLD;
            mm2h_pkg::S_KFOLD: begin
                state_next = status.last ? mm2h_pkg::S_AVAL_MUL : mm2h_pkg::S_IDLE;
            end
            mm2h_pkg::S_TAIL_MUL:  state_next = mm2h_pkg::S_TAIL_LOAD;
            mm2h_pkg::S_TAIL_LOAD: begin
                state_next = status.last ? mm2h_pkg::S_AVAL_MUL : mm2h_pkg::S_IDLE;
            end
            mm2h_pkg::S_AVAL_MUL:  state_next = mm2h_pkg::S_DONE;
            mm2h_pkg::S_DONE: begin
                if (status.out_free) begin
                    state_next = mm2h_pkg::S_IDLE;
                end
            end
            default:               state_next = mm2h_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.mul_op   = mm2h_pkg::MUL_HASH;
        cmd.h_op     = mm2h_pkg::H_HOLD;
        in_ready     = 1'b0;
        unique case (state_reg)
            mm2h_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    cmd.h_op = mm2h_pkg::H_START;
                end
            end
            mm2h_pkg::S_HMUL: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = mm2h_pkg::MUL_HASH;
            end
            mm2h_pkg::S_KMUL1: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = mm2h_pkg::MUL_WORD;
                cmd.h_op   = mm2h_pkg::H_PROD;
            end
            mm2h_pkg::S_KMUL2: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = mm2h_pkg::MUL_KSHIFT;
            end
            mm2h_pkg::S_KFOLD: begin
                cmd.h_op = mm2h_pkg::H_XOR_PROD;
            end
            mm2h_pkg::S_TAIL_MUL: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = mm2h_pkg::MUL_TAIL;
            end
            mm2h_pkg::S_TAIL_LOAD: begin
                cmd.h_op = mm2h_pkg::H_PROD;
            end
            mm2h_pkg::S_AVAL_MUL: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = mm2h_pkg::MUL_AVAL;
            end
            mm2h_pkg::S_DONE: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### design/mm2h_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm2h_datapath
// Hash state, seed register, shared 32x32 multiplier with registered
// product, and the result output register.
// ----------------------------------------------------------------------------
module mm2h_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mm2h_pkg::S_DATA_W-1:0] in_data,
    input  logic                          in_last,
    input  logic                          cfg_valid,
    input  logic [31:0]                   cfg_data,
    input  mm2h_pkg::dp_cmd_t             cmd,
    output mm2h_pkg::dp_status_t          status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mm2h_pkg::M_DATA_W-1:0] out_data
);

    logic [mm2h_pkg::WORD_W-1:0]  in_word;
    logic [mm2h_pkg::COUNT_W-1:0] in_count;
    logic [mm2h_pkg::LEN_W-1:0]   in_len;

    logic [31:0]          seed_reg;
    logic                 inside_reg;
    logic [31:0]          h_reg;
    logic [31:0]          h_next;
    logic [31:0]          word_reg;
    logic [1:0]           tail_cnt_reg;
    mm2h_pkg::cnt_class_t cls_reg;
    mm2h_pkg::cnt_class_t cls_next;
    logic                 last_reg;
    logic [31:0]          prod_reg;
    logic [31:0]          prod_next;
    logic [31:0]          mul_a;
    logic [31:0]          tail_mask;
    logic [31:0]          h_aval;
    logic                 out_valid_reg;
    logic [31:0]          out_data_reg;

    assign in_word  = in_data[31:0];
    assign in_count = in_data[34:32];
    assign in_len   = in_data[66:35];

    always_comb begin
        if (in_count == 3'd0) begin
            cls_next = mm2h_pkg::CNT_EMPTY;
        end else if (in_count[2]) begin
            cls_next = mm2h_pkg::CNT_FULL;
        end else begin
            cls_next = mm2h_pkg::CNT_PART;
        end
    end

    always_comb begin
        case (tail_cnt_reg)
            2'd3:    tail_mask = 32'h00ff_ffff;
            2'd2:    tail_mask = 32'h0000_ffff;
            default: tail_mask = 32'h0000_00ff;
        endcase
    end

    assign h_aval = h_reg ^ (h_reg >> mm2h_pkg::AVAL_SHIFT1);

    always_comb begin
        case (cmd.mul_op)
            mm2h_pkg::MUL_HASH:   mul_a = h_reg;
            mm2h_pkg::MUL_WORD:   mul_a = word_reg;
            mm2h_pkg::MUL_KSHIFT: mul_a = prod_reg ^ (prod_reg >> mm2h_pkg::MIX_SHIFT);
            mm2h_pkg::MUL_TAIL:   mul_a = h_reg ^ (word_reg & tail_mask);
            mm2h_pkg::MUL_AVAL:   mul_a = h_aval;
            default:              mul_a = h_reg;
        endcase
    end

    assign prod_next = mul_a * mm2h_pkg::MIX_MUL;

    always_comb begin
        case (cmd.h_op)
            mm2h_pkg::H_START:    h_next = inside_reg ? h_reg : (seed_reg ^ in_len);
            mm2h_pkg::H_PROD:     h_next = prod_reg;
            mm2h_pkg::H_XOR_PROD: h_next = h_reg ^ prod_reg;
            default:              h_next = h_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= '0;
            inside_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                seed_reg <= cfg_data;
            end
            if (cmd.load) begin
                inside_reg <= ~in_last;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        h_reg <= h_next;
        if (cmd.load) begin
            word_reg     <= in_word;
            tail_cnt_reg <= in_count[1:0];
            cls_reg      <= cls_next;
            last_reg     <= in_last;
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.out_load) begin
            out_data_reg <= prod_reg ^ (prod_reg >> mm2h_pkg::AVAL_SHIFT2);
        end
    end

    assign status.last     = last_reg;
    assign status.cls      = cls_reg;
    assign status.out_free = ~out_valid_reg | out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
